// ===== sv/mesh_vertex_normal_accumulator_assert.svh =====
// Assertion macros shared by the checker of the vertex normal block.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MVNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvna assertion failed");

// next-cycle implication, disabled during reset
`define MVNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvna assertion failed");

`endif

// ===== sv/mvna_pkg.sv =====
// Package: constants, types and helpers of the vertex normal accumulator.
`default_nettype none
package mvna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int COORD_BITS   = 24;
  localparam int IDX_W        = $clog2(VERTEX_COUNT);
  localparam int SUM_W        = 56;
  localparam int EDGE_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int NORM_BITS    = 30;
  localparam int SQ_W         = 2 * NORM_BITS + 2;
  localparam int RT_W         = 2 * NORM_BITS + 3;
  localparam int R_W          = NORM_BITS + 2;
  localparam int FRAC_W       = 16;
  localparam int Q_W          = 17;
  localparam int NUM_W        = NORM_BITS + FRAC_W + 2;
  localparam int NRM_W        = 16;
  localparam int IN_DATA_W    = 112;
  localparam int OUT_DATA_W   = 48;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_SKIP,
    ST_TRA, ST_TRB, ST_TRC, ST_TP2, ST_MUL,
    ST_ARD, ST_AWR, ST_RRD, ST_RGO, ST_RWAIT
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLD, N_DIV, N_DONE
  } nrm_state_t;

  typedef struct packed {
    logic             done;
    logic             degenerate;
    logic [NRM_W-1:0] nz;
    logic [NRM_W-1:0] ny;
    logic [NRM_W-1:0] nx;
  } nrm_res_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]   acc,
                                               input logic [CROSS_W-1:0] add);
    logic [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W+1-CROSS_W){add[CROSS_W-1]}}, add};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/mvna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/mvna_norm.sv =====
// Iterative normalizer: shift, sum of squares, integer root, Q1.15 divide.
`default_nettype none
module mvna_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mvna_pkg::SUM_W-1:0]  vx,
  input  logic [mvna_pkg::SUM_W-1:0]  vy,
  input  logic [mvna_pkg::SUM_W-1:0]  vz,
  output mvna_pkg::nrm_res_t          res
);

  localparam int SW = mvna_pkg::SUM_W;
  localparam int NB = mvna_pkg::NORM_BITS;
  localparam int QW = mvna_pkg::Q_W;
  localparam int NW = mvna_pkg::NRM_W;

  mvna_pkg::nrm_state_t st_r, st_nxt;

  logic [SW-1:0]                  a0_r, a1_r, a2_r;
  logic [2:0]                     neg_r;
  logic [1:0]                     sq_cnt_r;
  logic [2*NB-1:0]                prod_r;
  logic [mvna_pkg::SQ_W-1:0]      ss_r;
  logic [mvna_pkg::RT_W-1:0]      x_r, root_r, bit_r;
  logic [mvna_pkg::R_W-1:0]       r_r;
  logic [1:0]                     comp_r;
  logic [4:0]                     step_r;
  logic [mvna_pkg::R_W:0]         rem_r;
  logic [QW-1:0]                  nb_r, q_r;
  logic [NW-1:0]                  nx_r, ny_r, nz_r;
  logic                           degen_r;

  logic [SW-1:0]                  or_w;
  logic [mvna_pkg::RT_W-1:0]      trial, x_nxt, root_nxt;
  logic [mvna_pkg::NUM_W-1:0]     num;
  logic [mvna_pkg::R_W+1:0]       t_w, d_w, t_sub;
  logic                           ge;
  logic [QW-1:0]                  q_fin;
  logic [NW-1:0]                  q_sat, q_sgn;

  assign or_w = a0_r | a1_r | a2_r;

  always_comb begin
    trial = root_r + bit_r;
    if (x_r >= trial) begin
      x_nxt    = x_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      x_nxt    = x_r;
      root_nxt = root_r >> 1;
    end
  end

  always_comb begin
    num   = {2'b00, a0_r[NB-1:0], {mvna_pkg::FRAC_W{1'b0}}} + {{(mvna_pkg::NUM_W -
             mvna_pkg::R_W){1'b0}}, r_r};
    t_w   = {rem_r, nb_r[QW-1]};
    d_w   = {1'b0, r_r, 1'b0};
    ge    = (t_w >= d_w);
    t_sub = t_w - d_w;
    q_fin = {q_r[QW-2:0], ge};
    q_sat = (q_fin > {2'b00, {(QW-2){1'b1}}}) ? {1'b0, {(NW-1){1'b1}}} : q_fin[NW-1:0];
    q_sgn = neg_r[0] ? (~q_sat + 1'b1) : q_sat;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mvna_pkg::N_IDLE, mvna_pkg::N_DONE: if (start) st_nxt = mvna_pkg::N_SHIFT;
      mvna_pkg::N_SHIFT: begin
        if (or_w == '0) st_nxt = mvna_pkg::N_DONE;
        else if (!(|or_w[SW-1:NB])) st_nxt = mvna_pkg::N_SQ;
      end
      mvna_pkg::N_SQ:   if (sq_cnt_r == 2'd3) st_nxt = mvna_pkg::N_SQRT;
      mvna_pkg::N_SQRT: if (bit_r[0]) st_nxt = mvna_pkg::N_DLD;
      mvna_pkg::N_DLD:  st_nxt = mvna_pkg::N_DIV;
      mvna_pkg::N_DIV: begin
        if (step_r == 5'(QW - 1)) begin
          st_nxt = (comp_r == 2'd2) ? mvna_pkg::N_DONE : mvna_pkg::N_DLD;
        end
      end
      default: st_nxt = mvna_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    res.done       = (st_r == mvna_pkg::N_DONE);
    res.degenerate = degen_r;
    res.nx         = nx_r;
    res.ny         = ny_r;
    res.nz         = nz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mvna_pkg::N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      mvna_pkg::N_IDLE, mvna_pkg::N_DONE: begin
        if (start) begin
          a0_r    <= vx[SW-1] ? (~vx + 1'b1) : vx;
          a1_r    <= vy[SW-1] ? (~vy + 1'b1) : vy;
          a2_r    <= vz[SW-1] ? (~vz + 1'b1) : vz;
          neg_r   <= {vz[SW-1], vy[SW-1], vx[SW-1]};
          sq_cnt_r <= '0;
          ss_r    <= '0;
          comp_r  <= '0;
        end
      end
      mvna_pkg::N_SHIFT: begin
        if (or_w == '0) begin
          nx_r    <= '0;
          ny_r    <= '0;
          nz_r    <= '0;
          degen_r <= 1'b1;
        end else if (|or_w[SW-1:NB]) begin
          a0_r <= a0_r >> 1;
          a1_r <= a1_r >> 1;
          a2_r <= a2_r >> 1;
        end
      end
      mvna_pkg::N_SQ: begin
        sq_cnt_r <= sq_cnt_r + 1'b1;
        if (sq_cnt_r != 2'd3) begin
          prod_r <= a0_r[NB-1:0] * a0_r[NB-1:0];
          a0_r   <= a1_r;
          a1_r   <= a2_r;
          a2_r   <= a0_r;
          neg_r  <= {neg_r[0], neg_r[2:1]};
        end
        if (sq_cnt_r != 2'd0) begin
          ss_r <= ss_r + {2'b00, prod_r};
        end
        if (sq_cnt_r == 2'd3) begin
          x_r    <= {1'b0, ss_r + {2'b00, prod_r}};
          root_r <= '0;
          bit_r  <= {1'b1, {(mvna_pkg::RT_W-1){1'b0}}};
        end
      end
      mvna_pkg::N_SQRT: begin
        x_r    <= x_nxt;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        if (bit_r[0]) begin
          r_r <= (root_nxt == '0) ? mvna_pkg::R_W'(1) : root_nxt[mvna_pkg::R_W-1:0];
        end
      end
      mvna_pkg::N_DLD: begin
        rem_r  <= {2'b00, num[mvna_pkg::NUM_W-1:QW]};
        nb_r   <= num[QW-1:0];
        q_r    <= '0;
        step_r <= '0;
      end
      mvna_pkg::N_DIV: begin
        rem_r  <= ge ? t_sub[mvna_pkg::R_W:0] : t_w[mvna_pkg::R_W:0];
        nb_r   <= nb_r << 1;
        q_r    <= q_fin;
        step_r <= step_r + 1'b1;
        if (step_r == 5'(QW - 1)) begin
          nx_r    <= ny_r;
          ny_r    <= nz_r;
          nz_r    <= q_sgn;
          degen_r <= 1'b0;
          a0_r    <= a1_r;
          a1_r    <= a2_r;
          a2_r    <= a0_r;
          neg_r   <= {neg_r[0], neg_r[2:1]};
          comp_r  <= comp_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/mesh_vertex_normal_accumulator.sv =====
// Top level: area-weighted vertex normal accumulator over position and sum RAMs.
//
// Input channel in_*: one word is a command (in_tuser) with its operands.
//   load stores a position and zeroes that vertex's sums, triangle adds the
//   cross product (b-a)x(c-a) to the sums of a, b and c with saturation,
//   read returns the vertex's unit normal in Q1.15; unused codes are dropped.
// Output channel out_*: one word per read; out_tuser flags a zero vector.
// One item is worked at a time; in_tready is high only while idle.
//   triangle: three position reads, six products through one multiplier, three
//   read-modify-writes of the sum RAM. read: the normalizer runs a bit-serial
//   shift of up to 26 steps, a 32-step root and three 17-step divides; a zero
//   vector ends it at the shift step.
// After reset the sum RAM is zeroed, one entry a cycle, all 1024 entries, with
// in_tready low. Positions are undefined until loaded.
// A finished read waits in the output register; the next item is taken
// meanwhile, and a following read holds until that register is free.
`default_nettype none
module mesh_vertex_normal_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  logic [mvna_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // normal_x, normal_y, normal_z
  output logic [mvna_pkg::OUT_DATA_W-1:0]     out_tdata,
  // degenerate
  output logic                                out_tuser
);

  localparam int C  = mvna_pkg::COORD_BITS;
  localparam int IW = mvna_pkg::IDX_W;
  localparam int SW = mvna_pkg::SUM_W;
  localparam int EW = mvna_pkg::EDGE_W;
  localparam int XW = mvna_pkg::CROSS_W;

  mvna_pkg::top_state_t st_r, st_nxt;
  mvna_pkg::cmd_t       cmd;

  logic [IW-1:0]   clr_r, vtx_r, ca_r, cb_r, cc_r, corner;
  logic [C-1:0]    lx_r, ly_r, lz_r;
  logic [3*C-1:0]  p0_r, p1_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, op_a, op_b;
  logic signed [mvna_pkg::PROD_W-1:0] prod_r;
  logic [XW-1:0]   nx_r, ny_r, nz_r, prod_x;
  logic [2:0]      mul_cnt_r;
  logic [1:0]      k_r;

  logic                pos_we, sum_we, nrm_start, out_load, out_free;
  logic [IW-1:0]       pos_raddr, sum_waddr, sum_raddr;
  logic [3*C-1:0]      pos_rdata;
  logic [3*SW-1:0]     sum_wdata, sum_rdata;
  mvna_pkg::nrm_res_t  nrm_res;

  logic                out_valid_r, out_user_r;
  logic [mvna_pkg::OUT_DATA_W-1:0] out_data_r;

  assign cmd      = mvna_pkg::cmd_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign prod_x   = {prod_r[mvna_pkg::PROD_W-1], prod_r};

  always_comb begin
    case (k_r)
      2'd0:    corner = ca_r;
      2'd1:    corner = cb_r;
      default: corner = cc_r;
    endcase
  end

  always_comb begin
    case (mul_cnt_r)
      3'd0:    begin op_a = e1y_r; op_b = e2z_r; end
      3'd1:    begin op_a = e1z_r; op_b = e2y_r; end
      3'd2:    begin op_a = e1z_r; op_b = e2x_r; end
      3'd3:    begin op_a = e1x_r; op_b = e2z_r; end
      3'd4:    begin op_a = e1x_r; op_b = e2y_r; end
      3'd5:    begin op_a = e1y_r; op_b = e2x_r; end
      default: begin op_a = '0;    op_b = '0;    end
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mvna_pkg::ST_CLEAR: begin
        if (clr_r == IW'(mvna_pkg::VERTEX_COUNT - 1)) st_nxt = mvna_pkg::ST_IDLE;
      end
      mvna_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (cmd)
            mvna_pkg::CMD_LOAD: st_nxt = mvna_pkg::ST_LOAD;
            mvna_pkg::CMD_TRI:  st_nxt = mvna_pkg::ST_TRA;
            mvna_pkg::CMD_READ: st_nxt = mvna_pkg::ST_RRD;
            default:            st_nxt = mvna_pkg::ST_SKIP;
          endcase
        end
      end
      mvna_pkg::ST_LOAD, mvna_pkg::ST_SKIP: st_nxt = mvna_pkg::ST_IDLE;
      mvna_pkg::ST_TRA:  st_nxt = mvna_pkg::ST_TRB;
      mvna_pkg::ST_TRB:  st_nxt = mvna_pkg::ST_TRC;
      mvna_pkg::ST_TRC:  st_nxt = mvna_pkg::ST_TP2;
      mvna_pkg::ST_TP2:  st_nxt = mvna_pkg::ST_MUL;
      mvna_pkg::ST_MUL:  if (mul_cnt_r == 3'd6) st_nxt = mvna_pkg::ST_ARD;
      mvna_pkg::ST_ARD:  st_nxt = mvna_pkg::ST_AWR;
      mvna_pkg::ST_AWR:  st_nxt = (k_r == 2'd2) ? mvna_pkg::ST_IDLE : mvna_pkg::ST_ARD;
      mvna_pkg::ST_RRD:  st_nxt = mvna_pkg::ST_RGO;
      mvna_pkg::ST_RGO:  st_nxt = mvna_pkg::ST_RWAIT;
      mvna_pkg::ST_RWAIT: if (nrm_res.done && out_free) st_nxt = mvna_pkg::ST_IDLE;
      default: st_nxt = mvna_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    pos_we    = 1'b0;
    pos_raddr = corner;
    sum_we    = 1'b0;
    sum_waddr = vtx_r;
    sum_wdata = '0;
    sum_raddr = vtx_r;
    nrm_start = 1'b0;
    out_load  = 1'b0;
    unique case (st_r)
      mvna_pkg::ST_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_r;
      end
      mvna_pkg::ST_IDLE: in_tready = 1'b1;
      mvna_pkg::ST_LOAD: begin
        pos_we = 1'b1;
        sum_we = 1'b1;
      end
      mvna_pkg::ST_TRA: pos_raddr = ca_r;
      mvna_pkg::ST_TRB: pos_raddr = cb_r;
      mvna_pkg::ST_TRC: pos_raddr = cc_r;
      mvna_pkg::ST_ARD: sum_raddr = corner;
      mvna_pkg::ST_AWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner;
        sum_wdata = {mvna_pkg::sat_add(sum_rdata[3*SW-1:2*SW], nz_r),
                     mvna_pkg::sat_add(sum_rdata[2*SW-1:SW], ny_r),
                     mvna_pkg::sat_add(sum_rdata[SW-1:0], nx_r)};
      end
      mvna_pkg::ST_RGO:   nrm_start = 1'b1;
      mvna_pkg::ST_RWAIT: out_load  = nrm_res.done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mvna_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == mvna_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      vtx_r <= in_tdata[IW-1:0];
      lx_r  <= in_tdata[10+C-1:10];
      ly_r  <= in_tdata[34+C-1:34];
      lz_r  <= in_tdata[58+C-1:58];
      ca_r  <= in_tdata[82+IW-1:82];
      cb_r  <= in_tdata[92+IW-1:92];
      cc_r  <= in_tdata[102+IW-1:102];
    end
    if (st_r == mvna_pkg::ST_TRB) p0_r <= pos_rdata;
    if (st_r == mvna_pkg::ST_TRC) p1_r <= pos_rdata;
    if (st_r == mvna_pkg::ST_TP2) begin
      e1x_r     <= $signed({p1_r[C-1],     p1_r[C-1:0]})     -
                   $signed({p0_r[C-1],     p0_r[C-1:0]});
      e1y_r     <= $signed({p1_r[2*C-1],   p1_r[2*C-1:C]})   -
                   $signed({p0_r[2*C-1],   p0_r[2*C-1:C]});
      e1z_r     <= $signed({p1_r[3*C-1],   p1_r[3*C-1:2*C]}) -
                   $signed({p0_r[3*C-1],   p0_r[3*C-1:2*C]});
      e2x_r     <= $signed({pos_rdata[C-1],   pos_rdata[C-1:0]})     -
                   $signed({p0_r[C-1],        p0_r[C-1:0]});
      e2y_r     <= $signed({pos_rdata[2*C-1], pos_rdata[2*C-1:C]})   -
                   $signed({p0_r[2*C-1],      p0_r[2*C-1:C]});
      e2z_r     <= $signed({pos_rdata[3*C-1], pos_rdata[3*C-1:2*C]}) -
                   $signed({p0_r[3*C-1],      p0_r[3*C-1:2*C]});
      mul_cnt_r <= '0;
    end
    if (st_r == mvna_pkg::ST_MUL) begin
      mul_cnt_r <= mul_cnt_r + 1'b1;
      prod_r    <= op_a * op_b;
      case (mul_cnt_r)
        3'd1:    nx_r <= prod_x;
        3'd2:    nx_r <= nx_r - prod_x;
        3'd3:    ny_r <= prod_x;
        3'd4:    ny_r <= ny_r - prod_x;
        3'd5:    nz_r <= prod_x;
        3'd6:    nz_r <= nz_r - prod_x;
        default: ;
      endcase
      k_r <= '0;
    end
    if (st_r == mvna_pkg::ST_AWR) k_r <= k_r + 1'b1;
    if (out_load) begin
      out_data_r <= {nrm_res.nz, nrm_res.ny, nrm_res.nx};
      out_user_r <= nrm_res.degenerate;
    end
  end

  mvna_ram #(
    .WIDTH (3 * C),
    .DEPTH (mvna_pkg::VERTEX_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (vtx_r),
    .wdata ({lz_r, ly_r, lx_r}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  mvna_ram #(
    .WIDTH (3 * SW),
    .DEPTH (mvna_pkg::VERTEX_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  mvna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nrm_start),
    .vx    (sum_rdata[SW-1:0]),
    .vy    (sum_rdata[2*SW-1:SW]),
    .vz    (sum_rdata[3*SW-1:2*SW]),
    .res   (nrm_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ===== sv/mvna_chk.sv =====
// Port-level checker for the vertex normal accumulator, bound to the top level.
`default_nettype none
`include "mesh_vertex_normal_accumulator_assert.svh"
module mvna_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mvna_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  `MVNA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `MVNA_ASSERT_IMP(a_degen_zero, out_tvalid && out_tuser, out_tdata == '0)
  `MVNA_ASSERT_IMP(a_unit_nonzero, out_tvalid && !out_tuser, out_tdata != '0)
  `MVNA_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

endmodule

bind mesh_vertex_normal_accumulator mvna_chk u_chk (.*);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench of the area-weighted vertex normal accumulator.
`default_nettype none
module tb;

  localparam logic [23:0] C_MAX = 24'h7FFFFF;
  localparam logic [23:0] C_MIN = 24'h800000;
  localparam longint SUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 475;

  typedef struct {
    mvna_pkg::cmd_t cmd;
    logic [9:0]  vidx;
    logic [23:0] px, py, pz;
    logic [9:0]  ca, cb, cc;
    bit          typed;
    logic [47:0] exp_data;
    logic        exp_deg;
  } word_t;

  typedef struct {
    logic [47:0] data;
    logic        deg;
  } normal_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [mvna_pkg::IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic [mvna_pkg::OUT_DATA_W-1:0] out_tdata;

  int vertex_pos [3][1024];
  longint vertex_sum [3][1024];
  bit written [1024];
  normal_t normals_due [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit first_word = 1;
  word_t table_rows [$];

  mesh_vertex_normal_accumulator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic longint clamp_sum(longint s);
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_comp(longint v, int sh, longint unsigned r);
    longint unsigned a, q;
    longint n;
    a = magn(v) >> sh;
    q = (a * 65536 + r) / (2 * r);
    if (q > 32767) q = 32767;
    n = v < 0 ? -longint'(q) : longint'(q);
    return n[15:0];
  endfunction

  function automatic normal_t vertex_normal(int v);
    normal_t res;
    longint unsigned m, ax, ay, az, r;
    int sh;
    m = magn(vertex_sum[0][v]);
    if (magn(vertex_sum[1][v]) > m) m = magn(vertex_sum[1][v]);
    if (magn(vertex_sum[2][v]) > m) m = magn(vertex_sum[2][v]);
    if (m == 0) begin
      res.data = '0;
      res.deg = 1;
      return res;
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    ax = magn(vertex_sum[0][v]) >> sh;
    ay = magn(vertex_sum[1][v]) >> sh;
    az = magn(vertex_sum[2][v]) >> sh;
    r = root_floor(ax * ax + ay * ay + az * az);
    if (r == 0) r = 1;
    res.data = {unit_comp(vertex_sum[2][v], sh, r), unit_comp(vertex_sum[1][v], sh, r),
                unit_comp(vertex_sum[0][v], sh, r)};
    res.deg = 0;
    return res;
  endfunction

  // update state for an accepted word, queue its normal if it is a read
  function automatic void absorb_word(word_t w);
    longint e1 [3], e2 [3], n [3];
    int c [3];
    normal_t nr;
    case (w.cmd)
      mvna_pkg::CMD_LOAD: begin
        vertex_pos[0][w.vidx] = $signed(w.px);
        vertex_pos[1][w.vidx] = $signed(w.py);
        vertex_pos[2][w.vidx] = $signed(w.pz);
        for (int k = 0; k < 3; k++) vertex_sum[k][w.vidx] = 0;
        written[w.vidx] = 1;
      end
      mvna_pkg::CMD_TRI: begin
        c[0] = int'(w.ca); c[1] = int'(w.cb); c[2] = int'(w.cc);
        for (int k = 0; k < 3; k++) begin
          e1[k] = longint'(vertex_pos[k][c[1]]) - vertex_pos[k][c[0]];
          e2[k] = longint'(vertex_pos[k][c[2]]) - vertex_pos[k][c[0]];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            vertex_sum[k][c[j]] = clamp_sum(vertex_sum[k][c[j]] + n[k]);
      end
      mvna_pkg::CMD_READ: begin
        nr = vertex_normal(int'(w.vidx));
        if (w.typed) begin
          nr.data = w.exp_data;
          nr.deg = w.exp_deg;
        end
        normals_due.push_back(nr);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: data %h degenerate %b",
                                       out_tdata, out_tuser);
      end else begin
        e = normals_due.pop_front();
        if (out_tdata !== e.data || out_tuser !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x %h y %h z %h deg %b, got x %h y %h z %h deg %b",
                     e.data[15:0], e.data[31:16], e.data[47:32], e.deg,
                     out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser);
        end
      end
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_word(word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      if (!first_word) in_tvalid <= 0;
      first_word = 1;
      @(negedge clk);
    end
    first_word = 0;
    in_tdata <= {w.cc, w.cb, w.ca, w.pz, w.py, w.px, w.vidx};
    in_tuser <= w.cmd;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    absorb_word(w);
    @(negedge clk);
  endtask

  function automatic word_t junk_word(mvna_pkg::cmd_t cmd);
    word_t w;
    w.cmd = cmd;
    w.vidx = 10'($urandom); w.px = 24'($urandom); w.py = 24'($urandom);
    w.pz = 24'($urandom);
    w.ca = 10'($urandom); w.cb = 10'($urandom); w.cc = 10'($urandom);
    w.typed = 0; w.exp_data = '0; w.exp_deg = 0;
    return w;
  endfunction

  function automatic word_t load_row(int v, logic [23:0] x, logic [23:0] y, logic [23:0] z);
    word_t w = junk_word(mvna_pkg::CMD_LOAD);
    w.vidx = 10'(v); w.px = x; w.py = y; w.pz = z;
    return w;
  endfunction

  function automatic word_t tri_row(int a, int b, int c);
    word_t w = junk_word(mvna_pkg::CMD_TRI);
    w.ca = 10'(a); w.cb = 10'(b); w.cc = 10'(c);
    return w;
  endfunction

  function automatic word_t read_row(int v, bit typed, logic [47:0] d, logic deg);
    word_t w = junk_word(mvna_pkg::CMD_READ);
    w.vidx = 10'(v); w.typed = typed; w.exp_data = d; w.exp_deg = deg;
    return w;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return C_MAX;
      1: return C_MIN;
      2: return 24'($signed($urandom_range(31)) - 16);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_phase(int idle, int stall, bit hold_off, bit flip);
    int base, span, v, a, b, c, pick;
    word_t w;
    send_idle_pct = idle;
    stall_pct = stall;
    base = $urandom_range(1023);
    // a hot triangle driven into saturation
    send_word(load_row(base, C_MIN, C_MIN, C_MIN));
    send_word(load_row((base + 1) % 1024, C_MAX, C_MIN, C_MIN));
    send_word(load_row((base + 2) % 1024, C_MIN, C_MAX, C_MIN));
    for (int i = 0; i < 132; i++)
      if (flip) send_word(tri_row(base, (base + 2) % 1024, (base + 1) % 1024));
      else send_word(tri_row(base, (base + 1) % 1024, (base + 2) % 1024));
    for (int k = 0; k < 3; k++) send_word(read_row((base + k) % 1024, 0, '0, 0));
    for (int i = 0; i < PHASE_ITEMS - 138; i++) begin
      if (i % 100 == 0) begin
        base = $urandom_range(1023);
        case ($urandom_range(2))
          0: span = 4;
          1: span = 16;
          default: span = 1024;
        endcase
      end
      if (hold_off && i == 150) begin
        in_tvalid <= 0;
        first_word = 1;
        wait (normals_due.size() == 0);
        @(negedge clk);
      end
      v = (base + $urandom_range(span - 1)) % 1024;
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_word(load_row(v, rand_coord(), rand_coord(), rand_coord()));
      end else if (pick < 70) begin
        a = v;
        b = (base + $urandom_range(span - 1)) % 1024;
        c = $urandom_range(9) == 0 ? a : (base + $urandom_range(span - 1)) % 1024;
        if (!written[a]) send_word(load_row(a, rand_coord(), rand_coord(), rand_coord()));
        else if (!written[b]) send_word(load_row(b, rand_coord(), rand_coord(), rand_coord()));
        else if (!written[c]) send_word(load_row(c, rand_coord(), rand_coord(), rand_coord()));
        else send_word(tri_row(a, b, c));
      end else if (pick < 95) begin
        send_word(read_row($urandom_range(9) == 0 ? $urandom_range(1023) : v, 0, '0, 0));
      end else begin
        send_word(junk_word(mvna_pkg::CMD_NONE));
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 0;
    for (int i = 0; i < 1024; i++) begin
      written[i] = 0;
      for (int k = 0; k < 3; k++) begin
        vertex_pos[k][i] = 0;
        vertex_sum[k][i] = 0;
      end
    end
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed table
    table_rows.push_back(read_row(5, 1, '0, 1));
    table_rows.push_back(load_row(0, 0, 0, 0));
    table_rows.push_back(load_row(1, 0, 1, 0));
    table_rows.push_back(load_row(2, 0, 0, 1));
    table_rows.push_back(tri_row(0, 1, 2));
    table_rows.push_back(read_row(0, 1, {16'h0, 16'h0, 16'h7FFF}, 0));
    table_rows.push_back(read_row(1, 1, {16'h0, 16'h0, 16'h7FFF}, 0));
    table_rows.push_back(load_row(1023, C_MAX, C_MAX, C_MAX));
    table_rows.push_back(load_row(1022, C_MIN, C_MIN, C_MIN));
    table_rows.push_back(load_row(1021, C_MAX, C_MIN, 0));
    table_rows.push_back(tri_row(1022, 1023, 1021));
    table_rows.push_back(read_row(1021, 0, '0, 0));
    table_rows.push_back(tri_row(1021, 1021, 1022));
    table_rows.push_back(read_row(1022, 0, '0, 0));
    table_rows.push_back(junk_word(mvna_pkg::CMD_NONE));
    table_rows.push_back(read_row(1023, 0, '0, 0));
    table_rows.push_back(load_row(0, 0, 0, 0));
    table_rows.push_back(read_row(0, 1, '0, 1));
    table_rows.push_back(tri_row(0, 2, 1));
    table_rows.push_back(read_row(0, 1, {16'h0, 16'h0, 16'h8001}, 0));
    table_rows.push_back(read_row(2, 0, '0, 0));
    table_rows.push_back(read_row(1, 0, '0, 0));
    foreach (table_rows[i]) send_word(table_rows[i]);

    random_phase(0, 0, 0, 0);
    random_phase(84, 0, 1, 1);
    random_phase(0, 84, 0, 0);
    random_phase(12, 12, 0, 1);

    in_tvalid <= 0;
    stall_pct = 0;
    wait (normals_due.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
